@@ rtl/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg
// Types and fixed constants of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int ACTION_W    = 2;
	localparam int CHAR_W      = 8;
	localparam int COLUMN_W    = 7;
	localparam int ROW_W       = 5;
	localparam int CELL_IDX_W  = 11;
	localparam int CELL_W      = 16;
	localparam int CURSOR_W    = 11;
	localparam int COLOUR_W    = 4;
	localparam int CFG_INDEX_W = 1;

	localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_TEXT_COLOUR       = 1'b0,
		CFG_BACKGROUND_COLOUR = 1'b1
	} cfg_index_t;

	typedef enum logic [ACTION_W-1:0] {
		ACT_PUT_CHAR   = 2'd0,
		ACT_CLEAR      = 2'd1,
		ACT_SET_CURSOR = 2'd2,
		ACT_READ_CELL  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_INIT,   // zeroing sweep after reset
		ST_IDLE,
		ST_EXEC,   // memory read data available, finish or start a sweep
		ST_COPY,   // scroll: move rows up by one
		ST_BLANK,  // scroll: zero the last row
		ST_PLACE,  // scroll: write the character at the start of the last row
		ST_FILL    // clear: fill with background colour
	} state_t;

endpackage

@@ rtl/text_console_writer.sv @@
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console: screen of 16-bit cells in one synchronous RAM, a linear
// cursor, character put with scroll, clear, set cursor and cell read.
// ----------------------------------------------------------------------------
//  Channel  | Handshake              | Payload
//  ---------+------------------------+-------------------------------------------
//  in       | in_valid / in_ready    | action, char_code, column, row, cell_index
//  out      | out_valid / out_ready  | cell_data, cursor_position
//  cfg      | cfg_write_en           | cfg_index, cfg_data
//
// Put character, newline, set cursor and read cell do one RAM read, then the
// write-back and result. Scroll copies the rows up, blanks the last row and
// places the character (one RAM write a cycle); clear fills every cell.
// After reset a zeroing sweep over all COLUMNS*ROWS cells runs before in_ready rises.
// A new transaction is taken while the previous result waits in the output
// register; a finished operation stalls only if that register is still full.
// ----------------------------------------------------------------------------
module text_console_writer #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [tcw_pkg::ACTION_W-1:0]        action,
	input  logic [tcw_pkg::CHAR_W-1:0]          char_code,
	input  logic [tcw_pkg::COLUMN_W-1:0]        column,
	input  logic [tcw_pkg::ROW_W-1:0]           row,
	input  logic [tcw_pkg::CELL_IDX_W-1:0]      cell_index,

	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [tcw_pkg::CELL_W-1:0]          cell_data,
	output logic [tcw_pkg::CURSOR_W-1:0]        cursor_position,

	input  logic                                cfg_write_en,
	input  logic [tcw_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [tcw_pkg::COLOUR_W-1:0]        cfg_data
);

	import tcw_pkg::*;

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int CW    = $clog2(CELLS + 1);
	localparam int CW1   = CW + 1;
	localparam int COLW  = $clog2(COLUMNS);

	// screen RAM
	logic [CELL_W-1:0] mem [CELLS];
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic [CELL_W-1:0] rd_data_q;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [CELL_W-1:0] wr_data;

	state_t              state_q, state_d;
	logic [CW-1:0]       cursor_q, cursor_d;
	logic [COLW-1:0]     col_q, col_d;
	logic [CW-1:0]       ptr_q, ptr_d;

	action_t             act_q;
	logic [CHAR_W-1:0]   char_q;
	logic [COLUMN_W-1:0] col_in_q;
	logic [ROW_W-1:0]    row_in_q;
	logic                rd_ok_q;

	logic [COLOUR_W-1:0] text_colour_q;
	logic [COLOUR_W-1:0] background_colour_q;

	logic                out_valid_q;
	logic [CELL_W-1:0]   cell_data_q;
	logic [CURSOR_W-1:0] cursor_position_q;

	logic                in_fire;
	logic                slot_free;
	logic                cell_ok;
	logic                set_ok;
	logic [CW1-1:0]      nl_next;
	logic                out_load;
	logic [CELL_W-1:0]   res_data;

	assign in_ready        = (state_q == ST_IDLE);
	assign in_fire         = in_valid && in_ready;
	assign slot_free       = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;
	assign cell_data       = cell_data_q;
	assign cursor_position = cursor_position_q;

	assign cell_ok = (32'(cell_index) < 32'(CELLS));
	assign set_ok  = (32'(col_in_q) < 32'(COLUMNS)) && (32'(row_in_q) < 32'(ROWS));
	// start of next row: col_q tracks the column so no division is needed
	assign nl_next = {1'b0, cursor_q} + CW1'(COLUMNS) - CW1'(col_q);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_comb begin
		state_d  = state_q;
		cursor_d = cursor_q;
		col_d    = col_q;
		ptr_d    = ptr_q;
		rd_en    = 1'b0;
		rd_addr  = AW'(cursor_q);
		wr_en    = 1'b0;
		wr_addr  = AW'(ptr_q);
		wr_data  = '0;
		out_load = 1'b0;
		res_data = '0;

		case (state_q)
			ST_INIT: begin
				wr_en = 1'b1;
				ptr_d = ptr_q + CW'(1);
				if (ptr_q == CW'(CELLS - 1)) begin
					ptr_d   = '0;
					state_d = ST_IDLE;
				end
			end

			ST_IDLE: begin
				if (in_fire) begin
					state_d = ST_EXEC;
					if (action_t'(action) == ACT_READ_CELL) begin
						rd_en   = cell_ok;
						rd_addr = AW'(cell_index);
					end else begin
						rd_en   = (cursor_q != CW'(CELLS));
						rd_addr = AW'(cursor_q);
					end
				end
			end

			ST_EXEC: begin
				case (act_q)
					ACT_PUT_CHAR: begin
						if (char_q == NEWLINE_CODE) begin
							if (slot_free) begin
								cursor_d = (nl_next >= CW1'(CELLS)) ? CW'(CELLS) : CW'(nl_next);
								col_d    = '0;
								out_load = 1'b1;
								state_d  = ST_IDLE;
							end
						end else if (cursor_q == CW'(CELLS)) begin
							// past the end: scroll, first source is the second row
							rd_en   = 1'b1;
							rd_addr = AW'(COLUMNS);
							ptr_d   = CW'(COLUMNS + 1);
							state_d = ST_COPY;
						end else if (slot_free) begin
							wr_en    = 1'b1;
							wr_addr  = AW'(cursor_q);
							wr_data  = {rd_data_q[CELL_W-1 -: COLOUR_W], text_colour_q, char_q};
							cursor_d = cursor_q + CW'(1);
							col_d    = (col_q == COLW'(COLUMNS - 1)) ? '0 : col_q + COLW'(1);
							out_load = 1'b1;
							state_d  = ST_IDLE;
						end
					end
					ACT_CLEAR: begin
						ptr_d   = '0;
						state_d = ST_FILL;
					end
					ACT_SET_CURSOR: begin
						if (slot_free) begin
							if (set_ok) begin
								cursor_d = CW'(row_in_q) * CW'(COLUMNS) + CW'(col_in_q);
								col_d    = COLW'(col_in_q);
							end
							out_load = 1'b1;
							state_d  = ST_IDLE;
						end
					end
					ACT_READ_CELL: begin
						if (slot_free) begin
							res_data = rd_ok_q ? rd_data_q : '0;
							out_load = 1'b1;
							state_d  = ST_IDLE;
						end
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end

			ST_COPY: begin
				// data read last cycle from ptr_q-1 lands one row up
				wr_en   = 1'b1;
				wr_addr = AW'(ptr_q - CW'(COLUMNS + 1));
				wr_data = rd_data_q;
				if (ptr_q == CW'(CELLS)) begin
					ptr_d   = CW'(CELLS - COLUMNS);
					state_d = ST_BLANK;
				end else begin
					rd_en   = 1'b1;
					rd_addr = AW'(ptr_q);
					ptr_d   = ptr_q + CW'(1);
				end
			end

			ST_BLANK: begin
				wr_en = 1'b1;
				ptr_d = ptr_q + CW'(1);
				if (ptr_q == CW'(CELLS - 1)) begin
					state_d = ST_PLACE;
				end
			end

			ST_PLACE: begin
				if (slot_free) begin
					wr_en    = 1'b1;
					wr_addr  = AW'(CELLS - COLUMNS);
					wr_data  = {{COLOUR_W{1'b0}}, text_colour_q, char_q};
					cursor_d = CW'(CELLS - COLUMNS + 1);
					col_d    = COLW'(1);
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end

			ST_FILL: begin
				wr_en   = 1'b1;
				wr_data = {background_colour_q, {(CELL_W - COLOUR_W){1'b0}}};
				if (ptr_q == CW'(CELLS - 1)) begin
					if (slot_free) begin
						cursor_d = '0;
						col_d    = '0;
						out_load = 1'b1;
						state_d  = ST_IDLE;
					end
				end else begin
					ptr_d = ptr_q + CW'(1);
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_INIT;
			cursor_q <= '0;
			col_q    <= '0;
			ptr_q    <= '0;
		end else begin
			state_q  <= state_d;
			cursor_q <= cursor_d;
			col_q    <= col_d;
			ptr_q    <= ptr_d;
		end
	end

	// operands of the accepted transaction
	always_ff @(posedge clk) begin
		if (in_fire) begin
			act_q    <= action_t'(action);
			char_q   <= char_code;
			col_in_q <= column;
			row_in_q <= row;
			rd_ok_q  <= cell_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_colour_q       <= 4'hF;
			background_colour_q <= 4'h0;
		end else if (cfg_write_en) begin
			case (cfg_index_t'(cfg_index))
				CFG_TEXT_COLOUR:       text_colour_q       <= cfg_data;
				CFG_BACKGROUND_COLOUR: background_colour_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			cell_data_q       <= res_data;
			cursor_position_q <= CURSOR_W'(cursor_d);
		end
	end

endmodule
